[sv/a2p_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// a2p_pkg: shared types, constants and helpers for the atan2 polynomial unit
// Fixed-point formats, polynomial coefficients and Q15 rounding.
// ----------------------------------------------------------------------------
package a2p_pkg;

	localparam int CoordW   = 16;           // input coordinate width
	localparam int MagW     = CoordW + 1;   // magnitude, holds 32768
	localparam int NumW     = 32;           // dividend mn*2^15 + mx/2
	localparam int QuoW     = 16;           // ratio r in Q1.15, 0..32768
	localparam int DivStages = QuoW / 2;    // two quotient bits per stage
	localparam int ProdW    = 35;           // signed 18 x 17 product
	localparam int TermW    = 18;           // Horner accumulator
	localparam int AngW     = 20;           // reflection arithmetic, Q5.15
	localparam int PolyStages = 5;          // Horner steps after the seed

	localparam logic signed [AngW-1:0] HalfPiQ15 = 20'sd51472;
	localparam logic signed [AngW-1:0] PiQ15     = 20'sd102944;

	typedef struct packed {
		logic y_neg;
		logic x_neg;
		logic swap;     // |y| > |x|
		logic zero;     // both inputs zero
	} a2p_side_t;

	// Horner coefficients, Q1.15, highest order first
	function automatic logic signed [TermW-1:0] poly_coef(input logic [2:0] idx);
		logic signed [TermW-1:0] c;
		case (idx)
			3'd0:    c = -18'sd442;
			3'd1:    c = 18'sd1883;
			3'd2:    c = -18'sd3972;
			3'd3:    c = 18'sd6410;
			3'd4:    c = -18'sd10911;
			3'd5:    c = 18'sd32768;
			default: c = '0;
		endcase
		return c;
	endfunction

	// floor(p / 2^15 + 1/2)
	function automatic logic signed [AngW-1:0] rnd15(input logic signed [ProdW-1:0] p);
		logic signed [ProdW-1:0] b;
		b = p + 35'sd16384;
		return b[ProdW-1:15];
	endfunction

endpackage
`default_nettype wire

[sv/a2p_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// a2p_div: magnitude sort and pipelined ratio divider
// Sorts |x| and |y|, then forms r = (mn*2^15 + mx/2) / mx, two bits a stage.
// ----------------------------------------------------------------------------
module a2p_div import a2p_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     in_valid,
	input  wire logic signed [CoordW-1:0] y_coord,
	input  wire logic signed [CoordW-1:0] x_coord,
	output logic                          valid_out,
	output logic             [QuoW-1:0]   quo,
	output a2p_side_t                     side_out
);

	logic [MagW-1:0] ay, ax, mx, mn;
	logic [NumW-1:0] num;
	a2p_side_t       side;

	always_comb begin
		ay = y_coord[CoordW-1] ? (MagW'(0) - {y_coord[CoordW-1], y_coord})
		                       : {1'b0, y_coord};
		ax = x_coord[CoordW-1] ? (MagW'(0) - {x_coord[CoordW-1], x_coord})
		                       : {1'b0, x_coord};
		side.swap  = ay > ax;
		side.y_neg = y_coord[CoordW-1];
		side.x_neg = x_coord[CoordW-1];
		mx = side.swap ? ay : ax;
		mn = side.swap ? ax : ay;
		side.zero = (mx == '0);
		num = {mn, 15'b0} + {16'b0, mx[MagW-1:1]};
	end

	logic              valid_s1;
	logic [MagW-1:0]   mx_s1;
	logic [NumW-1:0]   num_s1;
	a2p_side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1   <= mx;
			num_s1  <= num;
			side_s1 <= side;
		end
	end

	// divider stage array, entry 0 is the prep register
	logic              valid_s [DivStages+1];
	logic [MagW-1:0]   rem_s   [DivStages+1];
	logic [15:0]       lo_s    [DivStages+1];
	logic [MagW-1:0]   mx_s    [DivStages+1];
	logic [QuoW-1:0]   q_s     [DivStages+1];
	a2p_side_t         side_s  [DivStages+1];

	assign valid_s[0] = valid_s1;
	assign rem_s[0]   = {1'b0, num_s1[NumW-1:16]};
	assign lo_s[0]    = num_s1[15:0];
	assign mx_s[0]    = mx_s1;
	assign q_s[0]     = '0;
	assign side_s[0]  = side_s1;

	for (genvar j = 0; j < DivStages; j++) begin : g_div
		logic [MagW:0]   t1, t2;
		logic [MagW-1:0] b1, b2;
		logic            g1, g2;

		always_comb begin
			t1 = {rem_s[j], lo_s[j][15]};
			g1 = t1 >= {1'b0, mx_s[j]};
			b1 = g1 ? MagW'(t1 - {1'b0, mx_s[j]}) : t1[MagW-1:0];
			t2 = {b1, lo_s[j][14]};
			g2 = t2 >= {1'b0, mx_s[j]};
			b2 = g2 ? MagW'(t2 - {1'b0, mx_s[j]}) : t2[MagW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (adv) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1]  <= b2;
				lo_s[j+1]   <= {lo_s[j][13:0], 2'b00};
				mx_s[j+1]   <= mx_s[j];
				q_s[j+1]    <= {q_s[j][QuoW-3:0], g1, g2};
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign valid_out = valid_s[DivStages];
	assign quo       = q_s[DivStages];
	assign side_out  = side_s[DivStages];

endmodule
`default_nettype wire

[sv/a2p_poly.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// a2p_poly: Horner evaluation pipeline
// Squares the ratio, then runs one multiply per stage over the coefficients,
// ending with the multiply by r that makes the polynomial odd.
// ----------------------------------------------------------------------------
module a2p_poly import a2p_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_valid,
	input  wire logic        [QuoW-1:0]  r,
	input  wire a2p_side_t               side_in,
	output logic                         valid_out,
	output logic signed      [ProdW-1:0] prod,
	output a2p_side_t                    side_out
);

	// square
	logic                    valid_s1;
	logic [ProdW-1:0]        sq_s1;
	logic [QuoW-1:0]         r_s1;
	a2p_side_t               side_s1;

	// seed multiply by the leading coefficient
	logic                    valid_s2;
	logic signed [ProdW-1:0] prod_s2;
	logic [QuoW-1:0]         r_s2;
	logic [QuoW-1:0]         sq_s2;
	a2p_side_t               side_s2;

	logic [QuoW-1:0]         s_rnd;
	logic signed [AngW-1:0]  s_full;

	assign s_full = rnd15(sq_s1);
	assign s_rnd  = s_full[QuoW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1   <= {3'b000, {{QuoW{1'b0}}, r} * {{QuoW{1'b0}}, r}};
			r_s1    <= r;
			side_s1 <= side_in;
			prod_s2 <= poly_coef(3'd0) * $signed({1'b0, s_rnd});
			r_s2    <= r_s1;
			sq_s2   <= s_rnd;
			side_s2 <= side_s1;
		end
	end

	logic                    valid_s [PolyStages+1];
	logic signed [ProdW-1:0] prod_s  [PolyStages+1];
	logic [QuoW-1:0]         r_s     [PolyStages+1];
	logic [QuoW-1:0]         sv_s    [PolyStages+1];
	a2p_side_t               side_s  [PolyStages+1];

	assign valid_s[0] = valid_s2;
	assign prod_s[0]  = prod_s2;
	assign r_s[0]     = r_s2;
	assign sv_s[0]    = sq_s2;
	assign side_s[0]  = side_s2;

	for (genvar k = 0; k < PolyStages; k++) begin : g_horner
		logic signed [AngW-1:0]  rp;
		logic signed [TermW-1:0] t;
		logic signed [QuoW:0]    op;

		always_comb begin
			rp = rnd15(prod_s[k]);
			t  = rp[TermW-1:0] + poly_coef(3'(k + 1));
			// last step multiplies by r instead of s
			op = (k == PolyStages - 1) ? $signed({1'b0, r_s[k]}) : $signed({1'b0, sv_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s[k+1] <= t * op;
				r_s[k+1]    <= r_s[k];
				sv_s[k+1]   <= sv_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid_out = valid_s[PolyStages];
	assign prod      = prod_s[PolyStages];
	assign side_out  = side_s[PolyStages];

endmodule
`default_nettype wire

[sv/atan2_polynomial_unit.sv]
`default_nettype none
// Four-quadrant arctangent of a signed 16-bit (y, x) pair, returned as signed
// Q3.13 radians in -pi..pi; both inputs zero give angle 0 with undefined_flag
// set. The unit is a 17-stage pipeline: one sort stage, eight divider stages
// retiring two ratio bits each, seven polynomial stages with one multiplier
// each, and the output register. It accepts one beat per cycle while not
// stalled; a stall on the output holds the whole pipeline, and coord_stall is
// raised only while a finished result waits in the output register.
// ----------------------------------------------------------------------------
// atan2_polynomial_unit: pipelined atan2 by polynomial approximation
// Ratio divider, Horner polynomial and octant/quadrant reflection.
// ----------------------------------------------------------------------------
module atan2_polynomial_unit import a2p_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     coord_valid,
	output logic                          coord_stall,
	input  wire logic signed [CoordW-1:0] y_coord,
	input  wire logic signed [CoordW-1:0] x_coord,
	output logic                          angle_valid,
	input  wire logic                     angle_stall,
	output logic signed [15:0]            angle,
	output logic                          undefined_flag
);

	logic adv;

	logic            div_valid;
	logic [QuoW-1:0] div_quo;
	a2p_side_t       div_side;

	logic                    poly_valid;
	logic signed [ProdW-1:0] poly_prod;
	a2p_side_t               poly_side;

	logic                 angle_valid_q;
	logic signed [15:0]   angle_q;
	logic                 flag_q;

	// advance everything unless a result is held at the output
	assign adv         = !angle_valid_q || !angle_stall;
	assign coord_stall = !adv;

	a2p_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (coord_valid),
		.y_coord  (y_coord),
		.x_coord  (x_coord),
		.valid_out(div_valid),
		.quo      (div_quo),
		.side_out (div_side)
	);

	a2p_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (div_valid),
		.r        (div_quo),
		.side_in  (div_side),
		.valid_out(poly_valid),
		.prod     (poly_prod),
		.side_out (poly_side)
	);

	logic signed [AngW-1:0] v, a0, a1, ac, ar;
	logic signed [15:0]     mag, ang;

	always_comb begin
		v  = rnd15(poly_prod);
		a0 = poly_side.swap  ? (HalfPiQ15 - v) : v;
		a1 = poly_side.x_neg ? (PiQ15 - a0) : a0;
		// clamp to 0..pi
		if (a1 < 0) begin
			ac = '0;
		end else if (a1 > PiQ15) begin
			ac = PiQ15;
		end else begin
			ac = a1;
		end
		ar  = ac + 20'sd2;
		mag = ar[17:2];
		ang = poly_side.y_neg ? -mag : mag;
		if (poly_side.zero) begin
			ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_valid_q <= 1'b0;
		end else if (adv) begin
			angle_valid_q <= poly_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q <= ang;
			flag_q  <= poly_side.zero;
		end
	end

	assign angle_valid    = angle_valid_q;
	assign angle          = angle_q;
	assign undefined_flag = flag_q;

endmodule
`default_nettype wire

[sv/a2p_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// a2p_checker: port-level assertions for the atan2 polynomial unit
// Input and output hold, flag coding, angle range and back-pressure coupling.
// ----------------------------------------------------------------------------
module a2p_checker import a2p_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     coord_valid,
	input wire logic                     coord_stall,
	input wire logic signed [CoordW-1:0] y_coord,
	input wire logic signed [CoordW-1:0] x_coord,
	input wire logic                     angle_valid,
	input wire logic                     angle_stall,
	input wire logic signed [15:0]       angle,
	input wire logic                     undefined_flag
);

	// a stalled coordinate beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && coord_stall |=>
			coord_valid && $stable(y_coord) && $stable(x_coord))
		else $error("stalled coordinate beat changed");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && angle_stall |=>
			angle_valid && $stable(angle) && $stable(undefined_flag))
		else $error("stalled result beat changed");

	// flagged beats carry a zero angle
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && undefined_flag |-> angle == 16'sd0)
		else $error("undefined beat with nonzero angle");

	// angle stays within -pi..pi
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> angle >= -16'sd25736 && angle <= 16'sd25736)
		else $error("angle out of range");

	// input side only stalls while a result is held
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(angle_valid && angle_stall) |-> !coord_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind atan2_polynomial_unit a2p_checker u_a2p_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.coord_valid   (coord_valid),
	.coord_stall   (coord_stall),
	.y_coord       (y_coord),
	.x_coord       (x_coord),
	.angle_valid   (angle_valid),
	.angle_stall   (angle_stall),
	.angle         (angle),
	.undefined_flag(undefined_flag)
);
`default_nettype wire

[tb/atan2_check.sv]
// ----------------------------------------------------------------------------
// atan2_check: result checker for the atan2 polynomial unit
// Watches both channels, computes the expected Q3.13 angle and zero flag for
// every coordinate beat taken, and compares them in order with the results.
// ----------------------------------------------------------------------------
module atan2_check import a2p_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     coord_valid,
	input  logic                     coord_stall,
	input  logic signed [CoordW-1:0] y_coord,
	input  logic signed [CoordW-1:0] x_coord,
	input  logic                     angle_valid,
	input  logic                     angle_stall,
	input  logic signed [15:0]       angle,
	input  logic                     undefined_flag,
	output int                       mismatches,
	output int                       pending,
	output int                       results_checked,
	output int                       zero_pairs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Horner coefficients in Q1.15, highest order first
	localparam longint C11 = -442;
	localparam longint C9  = 1883;
	localparam longint C7  = -3972;
	localparam longint C5  = 6410;
	localparam longint C3  = -10911;
	localparam longint C1  = 32768;

	localparam longint Q15_ONE     = 32768;
	localparam longint HALF_PI_Q15 = 51472;
	localparam longint PI_Q15      = 102944;

	typedef struct packed {
		logic signed [15:0] ang;
		logic               undef;
	} angle_expect_t;

	angle_expect_t expected_angles[$];

	// floor(p / 2^15 + 1/2)
	function automatic longint round_q15(input longint p);
		return (p + 64'sd16384) >>> 15;
	endfunction

	function automatic angle_expect_t predict_angle(input logic signed [CoordW-1:0] yv,
			input logic signed [CoordW-1:0] xv);
		longint ys, xs, ay, ax, mx, mn, r, s, t, v, a, ang;
		angle_expect_t e;
		ys = yv;
		xs = xv;
		ay = (ys < 0) ? -ys : ys;
		ax = (xs < 0) ? -xs : xs;
		mx = (ax > ay) ? ax : ay;
		mn = (ax > ay) ? ay : ax;
		if (mx == 0) begin
			e.ang   = '0;
			e.undef = 1'b1;
			return e;
		end
		r = (mn * Q15_ONE + mx / 2) / mx;
		if (r > Q15_ONE)
			r = Q15_ONE;
		s = round_q15(r * r);
		t = C11;
		t = round_q15(t * s) + C9;
		t = round_q15(t * s) + C7;
		t = round_q15(t * s) + C5;
		t = round_q15(t * s) + C3;
		t = round_q15(t * s) + C1;
		v = round_q15(t * r);
		// fold the first-octant angle out to the right octant, then quadrant
		a = v;
		if (ay > ax)
			a = HALF_PI_Q15 - a;
		if (xs < 0)
			a = PI_Q15 - a;
		if (a < 0)
			a = 0;
		if (a > PI_Q15)
			a = PI_Q15;
		ang = (a + 2) / 4;
		if (ys < 0)
			ang = -ang;
		e.ang   = ang[15:0];
		e.undef = 1'b0;
		return e;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		angle_expect_t want;
		if (!arst_n) begin
			expected_angles.delete();
			mismatches      = 0;
			pending         = 0;
			results_checked = 0;
			zero_pairs_seen = 0;
		end else begin
			if (coord_valid && !coord_stall)
				expected_angles.push_back(predict_angle(y_coord, x_coord));
			if (angle_valid && !angle_stall) begin
				if (expected_angles.size() == 0) begin
					report_mismatch($sformatf("angle beat %0d with flag %0b and nothing pending",
						angle, undefined_flag));
				end else begin
					want = expected_angles.pop_front();
					results_checked++;
					if (want.undef)
						zero_pairs_seen++;
					if (angle !== want.ang)
						report_mismatch($sformatf("result %0d: angle %0d, want %0d",
							results_checked, angle, want.ang));
					if (undefined_flag !== want.undef)
						report_mismatch($sformatf("result %0d: undefined_flag %0b, want %0b",
							results_checked, undefined_flag, want.undef));
				end
			end
			pending = expected_angles.size();
		end
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level for the atan2 polynomial unit
// Drives directed and random coordinate pairs under three idle profiles,
// stalls the result side at random, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench import a2p_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PER_PHASE = 443;
	localparam int IDLE_LIMIT       = 2000;
	localparam int DRAIN_CYCLES     = 40;

	logic                     clk;
	logic                     arst_n;
	logic                     coord_valid;
	logic                     coord_stall;
	logic signed [CoordW-1:0] y_coord;
	logic signed [CoordW-1:0] x_coord;
	logic                     angle_valid;
	logic                     angle_stall;
	logic signed [15:0]       angle;
	logic                     undefined_flag;

	int mismatches;
	int pending;
	int results_checked;
	int zero_pairs_seen;

	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	logic signed [CoordW-1:0] dir_y [24] = '{
		0, 0, 0, 1, -1, 32767, -32768, -32768, 32767, 0, -32768, 0,
		32767, 100, -100, 100, -100, 1, 32767, -1, -32768, -5, 5, -3
	};
	logic signed [CoordW-1:0] dir_x [24] = '{
		0, 1, -1, 0, 0, 32767, -32768, 32767, -32768, -32768, 0, 32767,
		0, 100, 100, -100, -100, 32767, 1, -32768, -1, 0, -3, 5
	};

	atan2_polynomial_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.coord_valid    (coord_valid),
		.coord_stall    (coord_stall),
		.y_coord        (y_coord),
		.x_coord        (x_coord),
		.angle_valid    (angle_valid),
		.angle_stall    (angle_stall),
		.angle          (angle),
		.undefined_flag (undefined_flag)
	);

	atan2_check angle_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.coord_valid     (coord_valid),
		.coord_stall     (coord_stall),
		.y_coord         (y_coord),
		.x_coord         (x_coord),
		.angle_valid     (angle_valid),
		.angle_stall     (angle_stall),
		.angle           (angle),
		.undefined_flag  (undefined_flag),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.zero_pairs_seen (zero_pairs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		angle_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((coord_valid && !coord_stall) || (angle_valid && !angle_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results pending",
					quiet_cycles, pending);
				$display("atan2_polynomial_unit: mismatch");
				$finish;
			end
		end
	end

	// call at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_coord(input logic signed [CoordW-1:0] yv,
			input logic signed [CoordW-1:0] xv);
		while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
			coord_valid <= 1'b0;
			@(negedge clk);
		end
		coord_valid <= 1'b1;
		y_coord     <= yv;
		x_coord     <= xv;
		do
			@(posedge clk);
		while (coord_stall);
		@(negedge clk);
	endtask

	task automatic send_random_coord();
		int mode;
		int m;
		int n;
		logic signed [CoordW-1:0] yv;
		logic signed [CoordW-1:0] xv;
		mode = $urandom_range(9);
		case (mode)
			0, 1, 2, 3: begin
				yv = CoordW'($urandom_range(65535));
				xv = CoordW'($urandom_range(65535));
			end
			4, 5: begin
				yv = CoordW'($urandom_range(16) - 8);
				xv = CoordW'($urandom_range(16) - 8);
			end
			6, 7: begin
				// near the diagonal, where the octant fold flips
				m = $urandom_range(32767);
				n = m + $urandom_range(4) - 2;
				if (n < 0)
					n = 0;
				if (n > 32767)
					n = 32767;
				yv = $urandom_range(1) ? CoordW'(m) : CoordW'(n);
				xv = (yv == m) ? CoordW'(n) : CoordW'(m);
				if ($urandom_range(1))
					yv = -yv;
				if ($urandom_range(1))
					xv = -xv;
			end
			8: begin
				case ($urandom_range(4))
					0:       m = 0;
					1:       m = 32767;
					2:       m = -32768;
					3:       m = 1;
					default: m = -1;
				endcase
				if ($urandom_range(1)) begin
					yv = CoordW'(m);
					xv = CoordW'($urandom_range(65535));
				end else begin
					xv = CoordW'(m);
					yv = CoordW'($urandom_range(65535));
				end
			end
			default: begin
				// ratio close to zero
				m = $urandom_range(65535);
				n = $urandom_range(6) - 3;
				if ($urandom_range(1)) begin
					yv = CoordW'(m);
					xv = CoordW'(n);
				end else begin
					yv = CoordW'(n);
					xv = CoordW'(m);
				end
			end
		endcase
		send_coord(yv, xv);
	endtask

	initial begin
		arst_n         = 1'b0;
		coord_valid    = 1'b0;
		y_coord        = '0;
		x_coord        = '0;
		angle_stall    = 1'b0;
		send_idle_pct  = 9;
		recv_stall_pct = 46;
		quiet_cycles   = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < 24; i++)
			send_coord(dir_y[i], dir_x[i]);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 9;
					recv_stall_pct = 46;
				end
				1: begin
					send_idle_pct  = 46;
					recv_stall_pct = 9;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				send_random_coord();
		end
		coord_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d angle results, %0d of them for a zero pair, over three idle profiles.",
			results_checked, zero_pairs_seen);
		if (mismatches == 0)
			$display("atan2_polynomial_unit: match");
		else
			$display("atan2_polynomial_unit: mismatch");
		$finish;
	end

endmodule
